// ----- rtl/core/ohlc_pkg.sv -----
package ohlc_pkg;

  // ring geometry and price scale
  localparam int CandleSlots = 53;
  localparam int SlotBits    = $clog2(CandleSlots);
  localparam int PriceLevels = 400;

  localparam int PriceW = 9;
  localparam int VolW   = 32;

  // axis state after reset
  localparam int AxisLowReset  = 150;
  localparam int AxisHighReset = 250;

  // floor(x/7) == (x*293) >> 11 for every x below 512
  localparam int RecipSeven = 293;
  localparam int RecipShift = 11;

  // configuration register indexes
  localparam logic [1:0] RegTicks   = 2'd0;
  localparam logic [1:0] RegFloor   = 2'd1;
  localparam logic [1:0] RegCeiling = 2'd2;
  localparam logic [1:0] RegSpan    = 2'd3;

  // signed working width of the axis arithmetic
  typedef logic signed [12:0] wide_t;

  typedef struct packed {
    logic take;       // latch the input transfer
    logic win;        // window update and ring write
    logic scan_step;  // read one ring slot
    logic calc_a;     // bounds and range
    logic calc_b;     // axis targets
    logic calc_c;     // smoothing and clamps
    logic load_out;   // move result to output register
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic scan_last;
  } sts_t;

  // floor(10*rem/7) for a remainder of a division by seven
  function automatic logic [3:0] tenth_sevenths(input logic [2:0] rem);
    logic [3:0] f;
    case (rem)
      3'd0:    f = 4'd0;
      3'd1:    f = 4'd1;
      3'd2:    f = 4'd2;
      3'd3:    f = 4'd4;
      3'd4:    f = 4'd5;
      3'd5:    f = 4'd7;
      3'd6:    f = 4'd8;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  // one smoothing step toward the target
  function automatic wide_t smooth_step(input wide_t cur, input wide_t tgt);
    wide_t d;
    wide_t adj;
    d = tgt - cur;
    if (d != 13'sd0 && d > -13'sd8 && d < 13'sd8) begin
      return (d > 13'sd0) ? cur + 13'sd1 : cur - 13'sd1;
    end
    adj = (d < 13'sd0) ? d + 13'sd7 : d;
    return cur + (adj >>> 3);
  endfunction

endpackage

// ----- rtl/core/ohlc_candle_autoscale_axis.sv -----
// a tick is taken in idle, then the window update runs, the ring scan reads the
//   n stored candles (0 to 53) one slot per cycle, and three axis steps follow
// new ticks stall until the last result moves to the output register
// the output register holds a result while the next tick is already taken
// reset: synchronous active-high rst restores the register defaults, an empty ring,
//   axis 150..250 and peak volume 1; ring contents are not cleared
module ohlc_candle_autoscale_axis (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  // tick input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         trade_price,
  input  logic [31:0]        cumulative_volume,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [9:0]  axis_bottom,
  output logic signed [10:0] axis_top,
  output logic               candle_done,
  output logic [8:0]         candle_open,
  output logic [8:0]         candle_high,
  output logic [8:0]         candle_low,
  output logic [8:0]         candle_close,
  output logic               candle_rising,
  output logic [31:0]        candle_volume,
  output logic [31:0]        volume_peak
);

  // commands from the sequencer, status back from the datapath
  ohlc_pkg::cmd_t cmd;
  ohlc_pkg::sts_t sts;

  // sequencer: idle, window update, ring scan, drain, three axis steps, result transfer
  ohlc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: configuration, candle window, low/high and volume rings, peak tracking,
  // axis target and smoothing, output register
  ohlc_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .trade_price       (trade_price),
    .cumulative_volume (cumulative_volume),
    .cmd               (cmd),
    .sts               (sts),
    .axis_bottom       (axis_bottom),
    .axis_top          (axis_top),
    .candle_done       (candle_done),
    .candle_open       (candle_open),
    .candle_high       (candle_high),
    .candle_low        (candle_low),
    .candle_close      (candle_close),
    .candle_rising     (candle_rising),
    .candle_volume     (candle_volume),
    .volume_peak       (volume_peak)
  );

endmodule

// ----- rtl/core/ohlc_ctrl.sv -----
module ohlc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  ohlc_pkg::sts_t sts,
  output ohlc_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_WIN    = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_DRAIN  = 8'b0000_1000,
    ST_CALC_A = 8'b0001_0000,
    ST_CALC_B = 8'b0010_0000,
    ST_CALC_C = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = ST_WIN;
      end
      ST_WIN: begin
        cmd.win    = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = !sts.fill_zero;
        if (sts.fill_zero || sts.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_CALC_A;
      ST_CALC_A: begin
        cmd.calc_a = 1'b1;
        state_next = ST_CALC_B;
      end
      ST_CALC_B: begin
        cmd.calc_b = 1'b1;
        state_next = ST_CALC_C;
      end
      ST_CALC_C: begin
        cmd.calc_c = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.load_out = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken result");

  a_take_win: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_WIN))
    else $error("accepted item did not start its window update");

  a_no_empty_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> !sts.fill_zero)
    else $error("ring read with no stored candle");

endmodule

// ----- rtl/core/ohlc_dp.sv -----
module ohlc_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic [8:0]          trade_price,
  input  logic [31:0]         cumulative_volume,
  input  ohlc_pkg::cmd_t      cmd,
  output ohlc_pkg::sts_t      sts,
  output logic signed [9:0]   axis_bottom,
  output logic signed [10:0]  axis_top,
  output logic                candle_done,
  output logic [8:0]          candle_open,
  output logic [8:0]          candle_high,
  output logic [8:0]          candle_low,
  output logic [8:0]          candle_close,
  output logic                candle_rising,
  output logic [31:0]         candle_volume,
  output logic [31:0]         volume_peak
);

  localparam int SB = ohlc_pkg::SlotBits;
  localparam int PW = ohlc_pkg::PriceW;
  localparam int VW = ohlc_pkg::VolW;

  // configuration
  logic [7:0]        cfg_ticks;
  logic signed [8:0] cfg_floor;
  logic [8:0]        cfg_ceiling;
  logic [7:0]        cfg_span;

  // input latch
  logic [PW-1:0] price_in;
  logic [VW-1:0] vol_in;

  // window and ring bookkeeping
  logic [7:0]    tick;
  logic [PW-1:0] open_px, high_price, low_price;
  logic [VW-1:0] vol_open, peak;
  logic [SB-1:0] head, fill;
  logic          rescan;

  // rings
  logic [2*PW-1:0] range_ring [0:ohlc_pkg::CandleSlots-1];
  logic [VW-1:0]   volume_ring [0:ohlc_pkg::CandleSlots-1];

  // scan
  logic [SB-1:0]   scan_addr;
  logic            rd_valid;
  logic [2*PW-1:0] rd_range;
  logic [VW-1:0]   rd_vol;
  logic [PW-1:0]   acc_lo, acc_hi;
  logic [VW-1:0]   acc_v;

  // per-tick candle result
  logic          res_done, res_rising;
  logic [PW-1:0] res_open, res_high, res_low, res_close;
  logic [VW-1:0] res_vol;

  // axis pipeline
  logic [PW-1:0]      lo_r, rng_r;
  logic signed [10:0] tmin_r;
  logic [9:0]         tspan_r;
  logic signed [9:0]  axis_low;
  logic signed [10:0] axis_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ticks   <= 8'd10;
      cfg_floor   <= -9'sd50;
      cfg_ceiling <= 9'd450;
      cfg_span    <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        ohlc_pkg::RegTicks:   cfg_ticks   <= cfg_data[7:0];
        ohlc_pkg::RegFloor:   cfg_floor   <= $signed(cfg_data);
        ohlc_pkg::RegCeiling: cfg_ceiling <= cfg_data;
        ohlc_pkg::RegSpan:    cfg_span    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      price_in <= trade_price;
      vol_in   <= cumulative_volume;
    end
  end

  // window update
  logic          first, complete, full, head_wrap;
  logic [7:0]    tick_inc;
  logic [PW-1:0] open_n, hi_base, lo_base, hi_n, lo_n;
  logic [VW-1:0] vol_open_n, cv;

  always_comb begin
    first      = (tick == 8'd0);
    open_n     = first ? price_in : open_px;
    hi_base    = first ? price_in : high_price;
    lo_base    = first ? price_in : low_price;
    hi_n       = (price_in > hi_base) ? price_in : hi_base;
    lo_n       = (price_in < lo_base) ? price_in : lo_base;
    vol_open_n = first ? vol_in : vol_open;
    cv         = vol_in - vol_open_n;
    tick_inc   = tick + 8'd1;
    complete   = (tick_inc >= cfg_ticks);
    full       = (fill == SB'(ohlc_pkg::CandleSlots));
    head_wrap  = (head == SB'(ohlc_pkg::CandleSlots - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick        <= '0;
      open_px     <= '0;
      high_price  <= '0;
      low_price   <= '1;
      vol_open    <= '0;
      peak        <= VW'(1);
      head        <= '0;
      fill        <= '0;
      rescan      <= 1'b0;
    end else if (cmd.win) begin
      open_px     <= open_n;
      vol_open    <= vol_open_n;
      rescan      <= complete && (cv < peak) && full;
      if (complete) begin
        tick       <= '0;
        high_price <= '0;
        low_price  <= '1;
        head       <= head_wrap ? '0 : head + SB'(1);
        if (!full) fill <= fill + SB'(1);
        if (cv >= peak) peak <= cv;
      end else begin
        tick       <= tick_inc;
        high_price <= hi_n;
        low_price  <= lo_n;
      end
    end else if (cmd.calc_a && rescan) begin
      peak <= acc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      res_done   <= complete;
      res_open   <= complete ? open_n : '0;
      res_high   <= complete ? hi_n : '0;
      res_low    <= complete ? lo_n : '0;
      res_close  <= complete ? price_in : '0;
      res_rising <= complete && (price_in >= open_n);
      res_vol    <= complete ? cv : '0;
    end
  end

  // ring memories
  always_ff @(posedge clk) begin
    if (cmd.win && complete) begin
      range_ring[head]  <= {lo_n, hi_n};
      volume_ring[head] <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_range <= range_ring[scan_addr];
      rd_vol   <= volume_ring[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.win) scan_addr <= '0;
      else if (cmd.scan_step) scan_addr <= scan_addr + SB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      acc_lo <= '1;
      acc_hi <= '0;
      acc_v  <= VW'(1);
    end else if (rd_valid) begin
      if (rd_range[2*PW-1:PW] < acc_lo) acc_lo <= rd_range[2*PW-1:PW];
      if (rd_range[PW-1:0] > acc_hi)    acc_hi <= rd_range[PW-1:0];
      if (rd_vol > acc_v)               acc_v  <= rd_vol;
    end
  end

  assign sts.fill_zero = (fill == '0);
  assign sts.scan_last = (scan_addr == fill - SB'(1));

  // bounds and range
  logic              incl;
  logic [PW-1:0]     lo_a, hi_a;
  logic signed [9:0] diff_a;

  always_comb begin
    incl   = (tick != 8'd0);
    lo_a   = (incl && low_price < acc_lo) ? low_price : acc_lo;
    hi_a   = (incl && high_price > acc_hi) ? high_price : acc_hi;
    diff_a = $signed({1'b0, hi_a}) - $signed({1'b0, lo_a});
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_a) begin
      lo_r  <= lo_a;
      rng_r <= (diff_a < $signed({2'b00, cfg_span})) ? {1'b0, cfg_span} : diff_a[8:0];
    end
  end

  // targets: bottom = trunc((7*lo - range)/7), span = floor(10*range/7)
  logic [17:0] prod;
  logic [6:0]  q, q_sel;
  logic [8:0]  q7, rem9;
  logic [11:0] lo7;
  logic        nonneg;

  always_comb begin
    prod   = {9'd0, rng_r} * 18'(ohlc_pkg::RecipSeven);
    q      = prod[17:ohlc_pkg::RecipShift];
    q7     = ({2'b00, q} << 3) - {2'b00, q};
    rem9   = rng_r - q7;
    lo7    = ({3'b000, lo_r} << 3) - {3'b000, lo_r};
    nonneg = (lo7 >= {3'b000, rng_r});
    q_sel  = (nonneg && rem9[2:0] != 3'd0) ? q + 7'd1 : q;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_b) begin
      tmin_r  <= $signed({2'b00, lo_r}) - $signed({4'b0000, q_sel});
      tspan_r <= ({q, 3'b000} + {2'b00, q, 1'b0})
                 + {6'd0, ohlc_pkg::tenth_sevenths(rem9[2:0])};
    end
  end

  // smoothing and clamps
  ohlc_pkg::wide_t tmin_w, tmax_w, lo_s, hi_s, lo_c, hi_c, floor_w, ceil_w, span_w;

  always_comb begin
    tmin_w  = {{2{tmin_r[10]}}, tmin_r};
    tmax_w  = tmin_w + $signed({3'b000, tspan_r});
    floor_w = {{4{cfg_floor[8]}}, cfg_floor};
    ceil_w  = $signed({4'b0000, cfg_ceiling});
    span_w  = $signed({5'b00000, cfg_span});
    lo_s    = ohlc_pkg::smooth_step({{3{axis_low[9]}}, axis_low}, tmin_w);
    hi_s    = ohlc_pkg::smooth_step({{2{axis_high[10]}}, axis_high}, tmax_w);
    lo_c    = (lo_s < floor_w) ? floor_w : lo_s;
    hi_c    = (hi_s > ceil_w) ? ceil_w : hi_s;
    if (hi_c - lo_c < span_w) hi_c = lo_c + span_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_low  <= 10'(ohlc_pkg::AxisLowReset);
      axis_high <= 11'(ohlc_pkg::AxisHighReset);
    end else if (cmd.calc_c) begin
      if (sts.fill_zero) begin
        axis_low  <= '0;
        axis_high <= 11'(ohlc_pkg::PriceLevels - 1);
      end else begin
        axis_low  <= lo_c[9:0];
        axis_high <= hi_c[10:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      axis_bottom   <= axis_low;
      axis_top      <= axis_high;
      candle_done   <= res_done;
      candle_open   <= res_open;
      candle_high   <= res_high;
      candle_low    <= res_low;
      candle_close  <= res_close;
      candle_rising <= res_rising;
      candle_volume <= res_vol;
      volume_peak   <= peak;
    end
  end

  a_head_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill != SB'(ohlc_pkg::CandleSlots)) |-> (head == fill))
    else $error("ring head and fill count out of step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (scan_addr < fill))
    else $error("ring read beyond stored candles");

  a_peak_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (peak != '0))
    else $error("peak volume dropped to zero");

endmodule
